/* sv/lfr_pkg.sv */
package lfr_pkg;

	// receiver phase codes
	localparam logic [2:0] PH_HUNT  = 3'd0;
	localparam logic [2:0] PH_FLAG  = 3'd1;
	localparam logic [2:0] PH_ADDR  = 3'd2;
	localparam logic [2:0] PH_CTRL  = 3'd3;
	localparam logic [2:0] PH_SETOK = 3'd4;
	localparam logic [2:0] PH_DATA  = 3'd5;

	// frame kinds, as reported in frame_type
	localparam logic [1:0] KIND_SET = 2'd0;
	localparam logic [1:0] KIND_I0  = 2'd1;
	localparam logic [1:0] KIND_I1  = 2'd2;

	// control bytes
	localparam logic [7:0] CTL_SET = 8'h08;
	localparam logic [7:0] CTL_I0  = 8'h80;
	localparam logic [7:0] CTL_I1  = 8'hC0;
	localparam logic [7:0] CTL_UA  = 8'h06;
	localparam logic [7:0] CTL_RR0 = 8'h11;
	localparam logic [7:0] CTL_RR1 = 8'h01;

	// configuration register indexes
	localparam logic [7:0] REG_STATION_ADDRESS = 8'd0;
	localparam logic [7:0] REG_FLAG_VALUE      = 8'd1;

	localparam logic [7:0] STATION_ADDRESS_RST = 8'h03;
	localparam logic [7:0] FLAG_VALUE_RST      = 8'h5C;

	localparam int unsigned REPLY_LEN = 5;

	// one reply request from the parser to the reply generator
	typedef struct packed {
		logic       ok;
		logic [1:0] kind;
	} reply_req_t;

	function automatic logic [7:0] kind_control(input logic [1:0] kind);
		case (kind)
			KIND_I0: kind_control = CTL_I0;
			KIND_I1: kind_control = CTL_I1;
			default: kind_control = CTL_SET;
		endcase
	endfunction

	function automatic logic [7:0] reply_control(input logic [1:0] kind);
		case (kind)
			KIND_I0: reply_control = CTL_RR0;
			KIND_I1: reply_control = CTL_RR1;
			default: reply_control = CTL_UA;
		endcase
	endfunction

endpackage

/* sv/lfr_parser.sv */
module lfr_parser import lfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] station_address,
	input  logic [7:0] flag_value,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       req_valid,
	input  logic       req_ready,
	output reply_req_t req
);

	logic [2:0] phase_q, phase_d;
	logic [1:0] kind_q, kind_d;
	logic [7:0] xor_q, xor_d;
	logic       seen_q, seen_d;
	logic       emit;
	reply_req_t emit_req;
	logic       req_valid_q;
	reply_req_t req_q;
	logic       accept;
	logic       is_flag;

	assign in_ready = !req_valid_q || req_ready;
	assign accept   = in_valid && in_ready;
	assign is_flag  = (in_byte == flag_value);

	always_comb begin
		phase_d  = phase_q;
		kind_d   = kind_q;
		xor_d    = xor_q;
		seen_d   = seen_q;
		emit     = 1'b0;
		emit_req = '{ok: 1'b0, kind: kind_q};
		case (phase_q)
			PH_FLAG: begin
				if (in_byte == station_address) phase_d = PH_ADDR;
				else if (is_flag)               phase_d = PH_FLAG;
				else                            phase_d = PH_HUNT;
			end
			PH_ADDR: begin
				if (in_byte == CTL_SET) begin
					kind_d  = KIND_SET;
					phase_d = PH_CTRL;
				end else if (in_byte == CTL_I0) begin
					kind_d  = KIND_I0;
					phase_d = PH_CTRL;
				end else if (in_byte == CTL_I1) begin
					kind_d  = KIND_I1;
					phase_d = PH_CTRL;
				end else if (is_flag) begin
					phase_d = PH_FLAG;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_CTRL: begin
				// BCC1 compare wins over a repeated flag
				if (in_byte == (station_address ^ kind_control(kind_q))) begin
					if (kind_q == KIND_I0 || kind_q == KIND_I1) begin
						xor_d   = '0;
						seen_d  = 1'b0;
						phase_d = PH_DATA;
					end else begin
						phase_d = PH_SETOK;
					end
				end else if (is_flag) begin
					phase_d = PH_FLAG;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_SETOK: begin
				phase_d = PH_HUNT;
				if (is_flag) begin
					emit     = 1'b1;
					emit_req = '{ok: 1'b0, kind: KIND_SET};
				end
			end
			PH_DATA: begin
				if (is_flag) begin
					phase_d  = PH_HUNT;
					emit     = 1'b1;
					emit_req = '{ok: seen_q && (xor_q == 8'h00), kind: kind_q};
				end else begin
					xor_d  = xor_q ^ in_byte;
					seen_d = 1'b1;
				end
			end
			default: begin
				phase_d = is_flag ? PH_FLAG : PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			kind_q  <= KIND_SET;
			xor_q   <= '0;
			seen_q  <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			kind_q  <= kind_d;
			xor_q   <= xor_d;
			seen_q  <= seen_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_q <= 1'b0;
		end else if (accept) begin
			req_valid_q <= emit;
		end else if (req_ready) begin
			req_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) req_q <= emit_req;
	end

	assign req_valid = req_valid_q;
	assign req       = req_q;

	// every reply request comes from a frame close, after which we hunt
	a_req_after_close: assert property (@(posedge clk) disable iff (!arst_n)
		accept && emit |=> req_valid_q && phase_q == PH_HUNT)
		else $error("reply request without return to hunting");

	a_phase_legal: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= PH_DATA)
		else $error("parser phase left the legal range");

	a_set_ok_zero: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid_q && req_q.kind == KIND_SET |-> !req_q.ok)
		else $error("SET reply flagged with a payload check");

endmodule

/* sv/lfr_reply_gen.sv */
module lfr_reply_gen import lfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] station_address,
	input  logic [7:0] flag_value,
	input  logic       req_valid,
	output logic       req_ready,
	input  reply_req_t req,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_last,
	output reply_req_t out_info
);

	logic       busy_q;
	logic [2:0] cnt_q;
	reply_req_t info_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	reply_req_t oinfo_q;
	logic       load;
	logic [7:0] ctl;
	logic [7:0] next_byte;

	assign req_ready = !busy_q;
	assign load      = busy_q && (!valid_q || out_ready);
	assign ctl       = reply_control(info_q.kind);

	always_comb begin
		case (cnt_q)
			3'd0:    next_byte = flag_value;
			3'd1:    next_byte = station_address;
			3'd2:    next_byte = ctl;
			3'd3:    next_byte = station_address ^ ctl;
			default: next_byte = flag_value;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (req_valid && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (load) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'(REPLY_LEN - 1)) busy_q <= 1'b0;
			end
			if (load)           valid_q <= 1'b1;
			else if (out_ready) valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !busy_q) info_q <= req;
		if (load) begin
			byte_q  <= next_byte;
			last_q  <= (cnt_q == 3'(REPLY_LEN - 1));
			oinfo_q <= info_q;
		end
	end

	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign out_last  = last_q;
	assign out_info  = oinfo_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q < 3'(REPLY_LEN))
		else $error("reply byte counter out of range");

	a_req_starts: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> busy_q && cnt_q == 3'd0)
		else $error("reply request not taken up");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		load && cnt_q == 3'(REPLY_LEN - 1) |=> !busy_q && out_last)
		else $error("reply did not end on its last byte");

endmodule

/* sv/link_frame_receiver.sv */
// channel   dir  handshake          payload
// s_axis    in   s_tvalid/s_tready  s_tdata: rx_byte
// m_axis    out  m_tvalid/m_tready  m_tdata: tx_byte, m_tlast: last_byte,
//                                   m_tuser: frame_type, payload_check_ok
// cfg       in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// One received byte per cycle is taken while no reply request waits for the reply
// generator. A closing byte raises a request at its edge; the generator takes it
// once idle and, while m_tready does not stall, loads one reply byte per cycle into
// its output register. The input is held only while a second request waits for
// the generator to load its fifth byte; a stall on m_tready holds the output
// register and so stretches that wait. Reset returns to flag hunting with defaults.
module link_frame_receiver import lfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] rx_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] tx_byte
	output logic       m_tlast,
	output logic [2:0] m_tuser,   // [1:0] frame_type, [2] payload_check_ok
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_index,
	input  logic [7:0] cfg_data
);

	logic [7:0] station_address_q;
	logic [7:0] flag_value_q;
	logic       req_valid;
	logic       req_ready;
	reply_req_t req;
	reply_req_t out_info;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station_address_q <= STATION_ADDRESS_RST;
			flag_value_q      <= FLAG_VALUE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_STATION_ADDRESS: station_address_q <= cfg_data;
				REG_FLAG_VALUE:      flag_value_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	lfr_parser u_parser (
		.clk             (clk),
		.arst_n          (arst_n),
		.station_address (station_address_q),
		.flag_value      (flag_value_q),
		.in_valid        (s_tvalid),
		.in_ready        (s_tready),
		.in_byte         (s_tdata),
		.req_valid       (req_valid),
		.req_ready       (req_ready),
		.req             (req)
	);

	lfr_reply_gen u_reply (
		.clk             (clk),
		.arst_n          (arst_n),
		.station_address (station_address_q),
		.flag_value      (flag_value_q),
		.req_valid       (req_valid),
		.req_ready       (req_ready),
		.req             (req),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.out_byte        (m_tdata),
		.out_last        (m_tlast),
		.out_info        (out_info)
	);

	assign m_tuser = {out_info.ok, out_info.kind};

endmodule
